// ----- rtl/mct_pkg.sv -----
// Shared types, field widths, command codes and deadline helpers of the compare timer.
package mct_pkg;

    localparam int CMD_W    = 2;
    localparam int CH_W     = 2;
    localparam int DUR_W    = 32;
    localparam int MASK_W   = 3;
    localparam int COUNT_W  = 32;

    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ONESHOT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PERIODIC = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STOP     = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [CH_W-1:0]  channel;
        logic [DUR_W-1:0] duration_ticks;
    } mct_item_t;

    // Decoded command, shared by every compare channel.
    typedef struct packed {
        logic tick;
        logic start;
        logic periodic;
        logic stop;
    } mct_ctrl_t;

    // What one channel reports about the word in flight.
    typedef struct packed {
        logic fired;
        logic armed;
        logic done;
    } mct_chan_stat_t;

    // Offset added to the count before the word when a channel is started.
    function automatic logic [DUR_W-1:0] start_offset(input logic [DUR_W-1:0] d);
        logic [DUR_W-1:0] off;
        off = (d > DUR_W'(2)) ? (d - DUR_W'(2)) : DUR_W'(1);
        return off;
    endfunction

    // Reload offset relative to the count before a tick; the tick's own
    // increment is folded in so that only one adder is needed.
    function automatic logic [DUR_W-1:0] reload_offset(input logic [DUR_W-1:0] p);
        logic [DUR_W-1:0] off;
        off = (p > DUR_W'(2)) ? (p - DUR_W'(1)) : DUR_W'(2);
        return off;
    endfunction

endpackage

// ----- rtl/mct_ifs.sv -----
// Valid/ready channel interfaces for command words and result words.
interface mct_req_if;
    logic                      valid;
    logic                      ready;
    logic [mct_pkg::CMD_W-1:0] cmd;
    logic [mct_pkg::CH_W-1:0]  channel;
    logic [mct_pkg::DUR_W-1:0] duration_ticks;

    modport source (output valid, cmd, channel, duration_ticks, input ready);
    modport sink   (input valid, cmd, channel, duration_ticks, output ready);
endinterface

interface mct_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [mct_pkg::MASK_W-1:0]  fired_mask;
    logic [mct_pkg::MASK_W-1:0]  done_mask;
    logic [mct_pkg::MASK_W-1:0]  armed_mask;
    logic [mct_pkg::COUNT_W-1:0] count_now;

    modport source (output valid, fired_mask, done_mask, armed_mask, count_now,
                    input ready);
    modport sink   (input valid, fired_mask, done_mask, armed_mask, count_now,
                    output ready);
endinterface

// ----- rtl/mct_in_stage.sv -----
// Input register stage that captures one command word per cycle while it is empty or its word moves on.
module mct_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    mct_req_if.sink            req,
    input  logic               advance,
    output logic               item_valid,
    output mct_pkg::mct_item_t item
);
    import mct_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    mct_item_t item_reg;
    logic      load;

    // The stage refills in the same cycle that its word moves on.
    assign req.ready  = !valid_reg || advance;
    assign load       = req.valid && req.ready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.cmd            <= req.cmd;
            item_reg.channel        <= req.channel;
            item_reg.duration_ticks <= req.duration_ticks;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/mct_channel.sv -----
// One output-compare channel: compare value, reload period, armed and done flags.
module mct_channel #(
    parameter int COUNT_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  mct_pkg::mct_ctrl_t          ctrl,
    input  logic                        sel,
    input  logic [COUNT_BITS-1:0]       count_cur,
    input  logic [COUNT_BITS-1:0]       count_inc,
    input  logic [mct_pkg::DUR_W-1:0]   duration_ticks,
    output mct_pkg::mct_chan_stat_t     stat
);
    import mct_pkg::*;

    localparam int SUM_W = (COUNT_BITS > DUR_W) ? COUNT_BITS : DUR_W;

    logic [COUNT_BITS-1:0] compare_reg;
    logic [COUNT_BITS-1:0] compare_next;
    logic [DUR_W-1:0]      period_reg;
    logic [DUR_W-1:0]      period_next;
    logic                  armed_reg;
    logic                  armed_next;
    logic                  done_reg;
    logic                  done_next;
    logic                  match;
    logic [DUR_W-1:0]      offset;
    logic [SUM_W-1:0]      deadline_sum;

    assign match = ctrl.tick && armed_reg && (compare_reg == count_inc);

    // One adder serves both the start deadline and the periodic reload.
    assign offset       = ctrl.tick ? reload_offset(period_reg)
                                    : start_offset(duration_ticks);
    assign deadline_sum = SUM_W'(count_cur) + SUM_W'(offset);

    always_comb
    begin
        compare_next = compare_reg;
        period_next  = period_reg;
        armed_next   = armed_reg;
        done_next    = done_reg;
        if (match)
        begin
            done_next = 1'b1;
            if (period_reg != '0)
            begin
                compare_next = deadline_sum[COUNT_BITS-1:0];
            end
            else
            begin
                armed_next = 1'b0;
            end
        end
        else if (sel && ctrl.stop)
        begin
            armed_next  = 1'b0;
            done_next   = 1'b1;
            period_next = '0;
        end
        else if (sel && ctrl.start)
        begin
            compare_next = deadline_sum[COUNT_BITS-1:0];
            period_next  = ctrl.periodic ? duration_ticks : '0;
            armed_next   = 1'b1;
            done_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (en)
        begin
            armed_reg <= armed_next;
            done_reg  <= done_next;
        end
    end

    // Compare and period are only looked at while the channel is armed.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            compare_reg <= compare_next;
            period_reg  <= period_next;
        end
    end

    assign stat.fired = match;
    assign stat.armed = armed_next;
    assign stat.done  = done_next;

endmodule

// ----- rtl/multi_channel_compare_timer.sv -----
// Top level of the multi-channel output-compare timer.
//
// Command words arrive on req: a tick advances the free-running counter by
// one, and a start (one-shot or periodic) or stop addresses one compare
// channel. Every word gives exactly one result word on rsp, carrying the
// channels that fired on that word, the done and armed flags afterwards,
// and the counter value afterwards.
// A word is captured in an input register and processed in a single pass
// into the result register, whose valid flag then presents the result to
// the receiver. One word is accepted in every cycle while the receiver
// takes results; the per-channel compare and the single deadline adder
// set the length of that cycle.
// While the receiver stalls with a result waiting, one further word may sit
// in the input register; req.ready then falls until the result is taken.
// Reset clears the counter and all armed and done flags; no word is in
// flight afterwards and the block accepts words at once.
module multi_channel_compare_timer #(
    parameter int CHANNELS   = 3,
    parameter int COUNT_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    mct_req_if.sink   req,
    mct_rsp_if.source rsp
);
    import mct_pkg::*;

    localparam int MW  = (CHANNELS > MASK_W) ? CHANNELS : MASK_W;
    localparam int CW  = (COUNT_BITS > COUNT_W) ? COUNT_BITS : COUNT_W;

    logic                  item_valid;
    mct_item_t             item;
    logic                  advance;
    mct_ctrl_t             ctrl;
    logic [CHANNELS-1:0]   sel;
    mct_chan_stat_t        stat [CHANNELS];
    logic [CHANNELS-1:0]   fired_vec;
    logic [CHANNELS-1:0]   armed_vec;
    logic [CHANNELS-1:0]   done_vec;
    logic [MW-1:0]         fired_wide;
    logic [MW-1:0]         armed_wide;
    logic [MW-1:0]         done_wide;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic [CW-1:0]         count_wide;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [MASK_W-1:0]     fired_reg;
    logic [MASK_W-1:0]     done_reg;
    logic [MASK_W-1:0]     armed_reg;
    logic [COUNT_W-1:0]    count_out_reg;

    mct_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    assign advance = item_valid && (!out_valid_reg || rsp.ready);

    assign ctrl.tick     = (item.cmd == CMD_TICK);
    assign ctrl.start    = (item.cmd == CMD_ONESHOT) || (item.cmd == CMD_PERIODIC);
    assign ctrl.periodic = (item.cmd == CMD_PERIODIC);
    assign ctrl.stop     = (item.cmd == CMD_STOP);

    assign count_inc  = count_reg + COUNT_BITS'(1);
    assign count_next = ctrl.tick ? count_inc : count_reg;

    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++)
        begin : g_chan
            // Channels beyond the decoded range are never selected.
            assign sel[c] = (int'(item.channel) == c);

            mct_channel #(
                .COUNT_BITS (COUNT_BITS)
            ) u_channel (
                .clk            (clk),
                .rst_n          (rst_n),
                .en             (advance),
                .ctrl           (ctrl),
                .sel            (sel[c]),
                .count_cur      (count_reg),
                .count_inc      (count_inc),
                .duration_ticks (item.duration_ticks),
                .stat           (stat[c])
            );

            assign fired_vec[c] = stat[c].fired;
            assign armed_vec[c] = stat[c].armed;
            assign done_vec[c]  = stat[c].done;
        end
    endgenerate

    assign fired_wide = MW'(fired_vec);
    assign armed_wide = MW'(armed_vec);
    assign done_wide  = MW'(done_vec);
    assign count_wide = CW'(count_next);

    assign out_valid_next = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fired_reg     <= fired_wide[MASK_W-1:0];
            done_reg      <= done_wide[MASK_W-1:0];
            armed_reg     <= armed_wide[MASK_W-1:0];
            count_out_reg <= count_wide[COUNT_W-1:0];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.fired_mask = fired_reg;
    assign rsp.done_mask  = done_reg;
    assign rsp.armed_mask = armed_reg;
    assign rsp.count_now  = count_out_reg;

    // The counter moves on tick words only.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !ctrl.tick |=> count_reg == $past(count_reg))
        else $error("counter advanced on a non-tick word");

    // Only a tick can make a channel fire.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !ctrl.tick |=> fired_reg == '0)
        else $error("fired flag on a non-tick word");

    // A channel that fires is always reported done.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.fired_mask & ~rsp.done_mask) == '0)
        else $error("fired channel not marked done");

    // With the result register empty nothing may hold back the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> req.ready)
        else $error("input stalled with an empty result register");

endmodule
